>>> design/mvwt_pkg.sv
// ---------------------------------------------------------------------------
// mvwt_pkg
// Shared types, constants and register indexes of the muon veto tracker.
// ---------------------------------------------------------------------------
package mvwt_pkg;

    localparam int TW = 62;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 30;
    localparam int DET_W = 3;
    localparam int STR_W = 24;
    localparam int DEF_RING_DEPTH = 1024;
    localparam int DEF_NUM_AD = 4;
    localparam logic [TW-1:0] MAX62 = {TW{1'b1}};

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_POOL   = 2'd1,
        CLS_AD     = 2'd2,
        CLS_SHOWER = 2'd3
    } cls_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_PRE        = 3'd0,
        REG_POOL_CUT   = 3'd1,
        REG_POOL_POST  = 3'd2,
        REG_AD_CUT     = 3'd3,
        REG_AD_POST    = 3'd4,
        REG_SHOW_CUT   = 3'd5,
        REG_SHOW_POST  = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_idx_t;

    // sequencer states of the tracker
    typedef enum logic [2:0] {
        ST_IDLE, ST_DEAD_END, ST_DEAD_ADD, ST_COMMIT, ST_QREAD, ST_QCHECK, ST_DONE
    } state_t;

    typedef struct packed {
        logic [19:0] pre;
        logic [9:0]  pool_cut;
        logic [29:0] pool_post;
        logic [23:0] ad_cut;
        logic [29:0] ad_post;
        logic [23:0] show_cut;
        logic [29:0] show_post;
    } cfg_t;

    // post-veto of a class under the current registers
    function automatic logic [29:0] post_of(input cls_t c, input cfg_t cfg);
        logic [29:0] r;
        begin
            case (c)
                CLS_POOL:   r = cfg.pool_post;
                CLS_AD:     r = cfg.ad_post;
                CLS_SHOWER: r = cfg.show_post;
                default:    r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/mvwt_cfg.sv
// ---------------------------------------------------------------------------
// mvwt_cfg
// Configuration register file with reset values.
// ---------------------------------------------------------------------------
module mvwt_cfg
    import mvwt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_PRE:       cfg_next.pre       = cfg_data[19:0];
                REG_POOL_CUT:  cfg_next.pool_cut  = cfg_data[9:0];
                REG_POOL_POST: cfg_next.pool_post = cfg_data;
                REG_AD_CUT:    cfg_next.ad_cut    = cfg_data[23:0];
                REG_AD_POST:   cfg_next.ad_post   = cfg_data;
                REG_SHOW_CUT:  cfg_next.show_cut  = cfg_data[23:0];
                REG_SHOW_POST: cfg_next.show_post = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre       <= 20'd2000;
            cfg_reg.pool_cut  <= 10'd12;
            cfg_reg.pool_post <= 30'd600000;
            cfg_reg.ad_cut    <= 24'd3000;
            cfg_reg.ad_post   <= 30'd1400000;
            cfg_reg.show_cut  <= 24'd300000;
            cfg_reg.show_post <= 30'd400400000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/mvwt_ring.sv
// ---------------------------------------------------------------------------
// mvwt_ring
// Ring memory of recent muons, one write and one registered read port.
// ---------------------------------------------------------------------------
module mvwt_ring
    import mvwt_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [TW-1:0] wtime,
    input  logic [4:0]    wcd,
    input  logic [AW-1:0] raddr,
    output logic [TW-1:0] rtime,
    output logic [4:0]    rcd
);

    logic [TW+4:0] mem [RING_DEPTH];
    logic [TW+4:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wcd, wtime};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rtime = rdata_reg[TW-1:0];
    assign rcd   = rdata_reg[TW+4:TW];

endmodule

>>> design/muon_veto_window_tracker_unit.sv
// ---------------------------------------------------------------------------
// muon_veto_window_tracker_unit
// Classifies muon records, accounts AD dead time and answers veto queries.
// ---------------------------------------------------------------------------
// channel | signals                                              | direction
// in      | in_valid in_ready kind stamp_ns detector strength    | request in
// out     | out_valid out_ready vetoed muon_class dead_time_ns   | result out
// cfg     | cfg_we cfg_index cfg_data                            | write only
//
// a query walks the ring newest first, up to fill entries, each entry a
// registered memory read, then a compare; the walk ends early on a veto or
// on an entry older than the shower post-veto
// a muon record visits each affected AD through the dead-time unit: every
// AD for a pool muon, its own AD for an AD or shower muon; a record that is
// not a muon goes straight to the result
// the ring needs no clearing pass; reset clears head, fill, the last muon
// times and the dead-time totals; one request at a time; in_ready stays low from accept until result taken
// ---------------------------------------------------------------------------
module muon_veto_window_tracker_unit
    import mvwt_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int NUM_AD = DEF_NUM_AD
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [TW-1:0]     stamp_ns,
    input  logic [DET_W-1:0]  detector,
    input  logic [STR_W-1:0]  strength,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              vetoed,
    output logic [1:0]        muon_class,
    output logic [TW-1:0]     dead_time_ns,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int ADW = (NUM_AD > 1) ? $clog2(NUM_AD) : 1;
    localparam logic [FW-1:0] FULL = FW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

    cfg_t cfg;
    state_t state_reg, state_next;

    logic [TW-1:0] t_reg, t_next;
    logic [DET_W-1:0] det_reg, det_next;
    cls_t cls_reg, cls_next;
    logic [ADW-1:0] ad_reg, ad_next;
    logic [TW+1:0] end_reg, end_next;
    logic [TW-1:0] pool_t_reg, pool_t_next;
    logic [TW-1:0] adt_reg [NUM_AD];
    logic [TW-1:0] sht_reg [NUM_AD];
    logic [TW-1:0] acc_reg [NUM_AD];
    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic vet_reg, vet_next;
    logic [TW-1:0] dead_reg, dead_next;
    logic acc_we;
    logic [TW-1:0] acc_wval;
    logic ring_we;
    logic [TW-1:0] r_time;
    logic [4:0] r_cd;
    logic is_pool, is_ad;
    logic [TW+1:0] e_pool, e_ad, e_sh, e_max;
    logic signed [TW+2:0] d, pre_s, post_s, eff, dt;
    logic [TW:0] sum;
    logic [29:0] post_q;
    cls_t rcls;

    mvwt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mvwt_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (head_reg),
        .wtime (t_reg),
        .wcd   ({cls_reg, det_reg}),
        .raddr (ptr_reg),
        .rtime (r_time),
        .rcd   (r_cd)
    );

    // detector decode on the input port
    assign is_pool = (detector == 3'd5) || (detector == 3'd6);
    assign is_ad = !is_pool && (detector >= 3'd1) && ({29'd0, detector} <= 32'(NUM_AD));

    // end of the latest veto on the current AD
    assign e_pool = {2'b00, pool_t_reg} + {34'd0, cfg.pool_post};
    assign e_ad   = {2'b00, adt_reg[ad_reg]} + {34'd0, cfg.ad_post};
    assign e_sh   = {2'b00, sht_reg[ad_reg]} + {34'd0, cfg.show_post};
    always_comb
    begin
        e_max = e_pool;
        if (e_ad > e_max) e_max = e_ad;
        if (e_sh > e_max) e_max = e_sh;
    end

    // effective dead time add
    assign pre_s  = {45'd0, cfg.pre};
    assign post_s = {35'd0, post_of(cls_reg, cfg)};
    assign d = {3'b000, t_reg} - {1'b0, end_reg};
    always_comb
    begin
        if (d >= pre_s)
            eff = pre_s + post_s;
        else if (d >= -post_s)
            eff = d + post_s;
        else
            eff = '0;
    end
    assign sum = {1'b0, acc_reg[ad_reg]} + eff[TW:0];

    // ring walk compare
    assign rcls = cls_t'(r_cd[4:3]);
    assign post_q = post_of(rcls, cfg);
    assign dt = {3'b000, t_reg} - {3'b000, r_time};

    always_comb
    begin
        state_next = state_reg;
        t_next = t_reg;
        det_next = det_reg;
        cls_next = cls_reg;
        ad_next = ad_reg;
        end_next = end_reg;
        pool_t_next = pool_t_reg;
        head_next = head_reg;
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        vet_next = vet_reg;
        dead_next = dead_reg;
        acc_we = 1'b0;
        acc_wval = sum[TW] ? MAX62 : sum[TW-1:0];
        ring_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    t_next = stamp_ns;
                    det_next = detector;
                    vet_next = 1'b0;
                    dead_next = '0;
                    cls_next = CLS_NONE;
                    ad_next = is_ad ? ADW'(detector - 3'd1) : '0;
                    if (kind)
                    begin
                        if (is_ad)
                            dead_next = acc_reg[ADW'(detector - 3'd1)];
                        cnt_next = fill_reg;
                        ptr_next = (head_reg == '0) ? LAST : head_reg - 1'b1;
                        state_next = ST_QREAD;
                    end
                    else
                    begin
                        if (is_pool && strength > {14'd0, cfg.pool_cut})
                            cls_next = CLS_POOL;
                        else if (is_ad && strength > cfg.show_cut)
                            cls_next = CLS_SHOWER;
                        else if (is_ad && strength > cfg.ad_cut)
                            cls_next = CLS_AD;
                        if (cls_next == CLS_NONE)
                            state_next = ST_DONE;
                        else
                            state_next = ST_DEAD_END;
                    end
                end
            end
            ST_DEAD_END:
            begin
                end_next = e_max;
                state_next = ST_DEAD_ADD;
            end
            ST_DEAD_ADD:
            begin
                acc_we = 1'b1;
                if (cls_reg == CLS_POOL && {{(32-ADW){1'b0}}, ad_reg} != 32'(NUM_AD - 1))
                begin
                    ad_next = ad_reg + 1'b1;
                    state_next = ST_DEAD_END;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                ring_we = 1'b1;
                if (cls_reg == CLS_POOL)
                    pool_t_next = t_reg;
                head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
                if (fill_reg != FULL)
                    fill_next = fill_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_QREAD:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_QCHECK;
            end
            ST_QCHECK:
            begin
                cnt_next = cnt_reg - 1'b1;
                ptr_next = (ptr_reg == '0) ? LAST : ptr_reg - 1'b1;
                state_next = ST_QREAD;
                if (dt > $signed({33'd0, cfg.show_post}))
                    state_next = ST_DONE;
                else if (dt < -pre_s)
                    state_next = ST_QREAD;
                else if (rcls != CLS_POOL && r_cd[2:0] != det_reg)
                    state_next = ST_QREAD;
                else if ((-pre_s < dt && dt < 0) || dt < $signed({35'd0, post_q}))
                begin
                    vet_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and accounting registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pool_t_reg <= '0;
            head_reg <= '0;
            fill_reg <= '0;
            for (int i = 0; i < NUM_AD; i++)
            begin
                adt_reg[i] <= '0;
                sht_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pool_t_reg <= pool_t_next;
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (acc_we)
                acc_reg[ad_reg] <= acc_wval;
            if (ring_we && cls_reg == CLS_AD)
                adt_reg[ad_reg] <= t_reg;
            if (ring_we && cls_reg == CLS_SHOWER)
                sht_reg[ad_reg] <= t_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        det_reg <= det_next;
        cls_reg <= cls_next;
        ad_reg <= ad_next;
        end_reg <= end_next;
        cnt_reg <= cnt_next;
        ptr_reg <= ptr_next;
        vet_reg <= vet_next;
        dead_reg <= dead_next;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign vetoed = vet_reg;
    assign muon_class = cls_reg;
    assign dead_time_ns = dead_reg;

`ifndef SYNTHESIS
    // fill never exceeds the ring depth
    a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FULL)
        else $error("ring fill beyond depth");
    // ring written only in commit
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (cls_reg != CLS_NONE))
        else $error("ring write without muon");
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(vetoed) && $stable(muon_class))
        else $error("result changed under stall");
    // a query result carries no class
    a_qcls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QCHECK) |-> (cls_reg == CLS_NONE))
        else $error("query carries class");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the muon veto tracker: muon records and veto queries are driven
// through the valid/ready request channel while a local tracker predicts
// each reply that the opening table does not script. Several register
// settings are covered, including extremes, random idling on both sides, and a ring wrap phase.
// ---------------------------------------------------------------------------
module testbench;
    import mvwt_pkg::*;

    // short ring so the wrap phase stays brief
    localparam int RING_N = 64;
    localparam int AD_N = DEF_NUM_AD;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              kind;
    logic [TW-1:0]     stamp_ns;
    logic [DET_W-1:0]  detector;
    logic [STR_W-1:0]  strength;
    logic              out_valid;
    logic              out_ready;
    logic              vetoed;
    logic [1:0]        muon_class;
    logic [TW-1:0]     dead_time_ns;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    typedef struct packed {
        logic          vetoed;
        logic [1:0]    cls;
        logic [TW-1:0] dead;
    } veto_reply_t;

    typedef struct {
        logic          kind;
        logic [TW-1:0] stamp;
        logic [2:0]    det;
        logic [23:0]   str;
        bit            typed;
        veto_reply_t   reply;
    } scripted_request_t;

    muon_veto_window_tracker_unit #(
        .RING_DEPTH (RING_N),
        .NUM_AD     (AD_N)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .stamp_ns     (stamp_ns),
        .detector     (detector),
        .strength     (strength),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vetoed       (vetoed),
        .muon_class   (muon_class),
        .dead_time_ns (dead_time_ns),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // tracker state mirrored from the block
    cfg_t          trk_cfg;
    logic [TW-1:0] last_pool;
    logic [TW-1:0] last_ad [AD_N];
    logic [TW-1:0] last_shower [AD_N];
    logic [63:0]   dead_acc [AD_N];
    logic [TW-1:0] ring_stamp [RING_N];
    logic [1:0]    ring_cls [RING_N];
    logic [2:0]    ring_det [RING_N];
    int            ring_head;
    int            ring_fill;

    veto_reply_t   reply_q[$];
    int            error_count;
    int            cycle_count;
    bit            quiet;
    int            stall_left;
    logic [TW-1:0] cursor_ns;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // runaway guard
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] post_for(input logic [1:0] c);
        case (c)
            CLS_POOL:   return 64'(trk_cfg.pool_post);
            CLS_AD:     return 64'(trk_cfg.ad_post);
            CLS_SHOWER: return 64'(trk_cfg.show_post);
            default:    return 64'd0;
        endcase
    endfunction

    // add clipped dead time for one muon on one AD
    function automatic void charge_dead(input int a, input logic [TW-1:0] t,
                                        input logic [1:0] c);
        logic [63:0] e, x, y, sum;
        longint d, pre, post, eff;
        e = 64'(last_pool) + 64'(trk_cfg.pool_post);
        x = 64'(last_ad[a]) + 64'(trk_cfg.ad_post);
        y = 64'(last_shower[a]) + 64'(trk_cfg.show_post);
        if (x > e) e = x;
        if (y > e) e = y;
        d = longint'(64'(t)) - longint'(e);
        pre = longint'(64'(trk_cfg.pre));
        post = longint'(post_for(c));
        if (d >= pre) eff = pre + post;
        else if (d >= -post) eff = d + post;
        else eff = 0;
        sum = dead_acc[a] + 64'(eff);
        dead_acc[a] = (sum > 64'(MAX62)) ? 64'(MAX62) : sum;
    endfunction

    // walk stored muons newest first
    function automatic logic veto_walk(input logic [TW-1:0] t, input logic [2:0] det);
        int idx;
        longint dt, pre;
        pre = longint'(64'(trk_cfg.pre));
        for (int k = 0; k < ring_fill; k++)
        begin
            idx = (ring_head + RING_N - 1 - k) % RING_N;
            dt = longint'(64'(t)) - longint'(64'(ring_stamp[idx]));
            if (dt > longint'(64'(trk_cfg.show_post))) return 1'b0;
            if (dt < -pre) continue;
            if (ring_cls[idx] != CLS_POOL && ring_det[idx] != det) continue;
            if (-pre < dt && dt < 0) return 1'b1;
            if (dt < longint'(post_for(ring_cls[idx]))) return 1'b1;
        end
        return 1'b0;
    endfunction

    // predict the reply to one request and advance the tracker
    function automatic veto_reply_t track_event(input logic k, input logic [TW-1:0] t,
                                                input logic [2:0] det,
                                                input logic [23:0] s);
        veto_reply_t r;
        logic [1:0] c;
        bit pool_det, ad_det;
        r = '0;
        c = CLS_NONE;
        pool_det = (det == 3'd5 || det == 3'd6);
        ad_det = (det >= 3'd1 && det <= 3'(AD_N));
        if (k)
        begin
            r.vetoed = veto_walk(t, det);
            if (ad_det) r.dead = dead_acc[det - 1][TW-1:0];
            return r;
        end
        if (pool_det && s > 24'(trk_cfg.pool_cut)) c = CLS_POOL;
        else if (ad_det && s > trk_cfg.show_cut) c = CLS_SHOWER;
        else if (ad_det && s > trk_cfg.ad_cut) c = CLS_AD;
        if (c == CLS_NONE) return r;
        if (c == CLS_POOL)
        begin
            for (int a = 0; a < AD_N; a++) charge_dead(a, t, c);
            last_pool = t;
        end
        else
        begin
            charge_dead(det - 1, t, c);
            if (c == CLS_SHOWER) last_shower[det - 1] = t;
            else last_ad[det - 1] = t;
        end
        ring_stamp[ring_head] = t;
        ring_cls[ring_head] = c;
        ring_det[ring_head] = det;
        ring_head = (ring_head + 1) % RING_N;
        if (ring_fill < RING_N) ring_fill++;
        r.cls = c;
        return r;
    endfunction

    // reply checker
    task automatic flag_field(input string what, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        veto_reply_t e;
        if (out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10) $display("mismatch: reply with no request pending");
            end
            else
            begin
                e = reply_q.pop_front();
                if (vetoed !== e.vetoed) flag_field("vetoed", 64'(e.vetoed), 64'(vetoed));
                if (muon_class !== e.cls) flag_field("muon_class", 64'(e.cls), 64'(muon_class));
                if (dead_time_ns !== e.dead)
                    flag_field("dead_time_ns", 64'(e.dead), 64'(dead_time_ns));
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_request(input logic k, input logic [TW-1:0] t, input logic [2:0] d,
                                input logic [23:0] s, input bit typed,
                                input veto_reply_t typed_r);
        veto_reply_t r;
        in_valid <= 1'b1;
        kind <= k;
        stamp_ns <= t;
        detector <= d;
        strength <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = track_event(k, t, d, s);
        if (typed) r = typed_r;
        reply_q.push_back(r);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // wait until every reply is in and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            REG_PRE:       trk_cfg.pre = v[19:0];
            REG_POOL_CUT:  trk_cfg.pool_cut = v[9:0];
            REG_POOL_POST: trk_cfg.pool_post = v;
            REG_AD_CUT:    trk_cfg.ad_cut = v[23:0];
            REG_AD_POST:   trk_cfg.ad_post = v;
            REG_SHOW_CUT:  trk_cfg.show_cut = v[23:0];
            REG_SHOW_POST: trk_cfg.show_post = v;
            default:       ;
        endcase
    endtask

    task automatic write_all(input logic [19:0] pre, input logic [9:0] pcut,
                             input logic [29:0] ppost, input logic [23:0] acut,
                             input logic [29:0] apost, input logic [23:0] scut,
                             input logic [29:0] spost);
        write_reg(REG_PRE, 30'(pre));
        write_reg(REG_POOL_CUT, 30'(pcut));
        write_reg(REG_POOL_POST, ppost);
        write_reg(REG_AD_CUT, 30'(acut));
        write_reg(REG_AD_POST, apost);
        write_reg(REG_SHOW_CUT, 30'(scut));
        write_reg(REG_SHOW_POST, spost);
        // unused index must be ignored
        write_reg(REG_UNUSED, {CFG_DW{1'b1}});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_strength(input logic [2:0] det);
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'(trk_cfg.pool_cut) + 24'($urandom_range(0, 2)) - 24'd1;
            2: return trk_cfg.ad_cut + 24'($urandom_range(0, 2)) - 24'd1;
            3: return trk_cfg.show_cut + 24'($urandom_range(0, 2)) - 24'd1;
            4: return (det >= 3'd5) ? 24'($urandom_range(0, 1023)) : 24'($urandom);
            default: return 24'($urandom_range(0, 400000));
        endcase
    endfunction

    // random request, mostly walking forward in time near recent muons
    task automatic random_request(input bit muon_only);
        logic k;
        logic [2:0] d;
        logic [23:0] s;
        logic [TW-1:0] t;
        int sel;
        k = muon_only ? 1'b0 : ($urandom_range(0, 9) < 6);
        sel = $urandom_range(0, 99);
        if (sel < 55) cursor_ns = cursor_ns + TW'($urandom_range(0, 4000));
        else if (sel < 85) cursor_ns = cursor_ns + TW'($urandom_range(0, 3000000));
        else if (sel < 97) cursor_ns = cursor_ns + TW'($urandom_range(0, 600000000));
        else cursor_ns = TW'({$urandom, $urandom});
        t = cursor_ns;
        if (k && $urandom_range(0, 3) == 0) t = cursor_ns - TW'($urandom_range(0, 6000));
        sel = $urandom_range(0, 99);
        if (sel < 40) d = 3'd5 + 3'($urandom_range(0, 1));
        else if (sel < 94) d = 3'($urandom_range(1, AD_N));
        else d = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
        s = pick_strength(d);
        if (muon_only)
        begin
            if (d == 3'd0 || d == 3'd7) d = 3'd5;
            s = 24'hFFFFFF - 24'($urandom_range(0, 1000));
        end
        send_request(k, t, d, s, 1'b0, '0);
    endtask

    scripted_request_t opening_rows [24] = '{
        '{1'b1, 62'd0,          3'd1, 24'd0,       1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b1, T_MAX,          3'd7, 24'hFFFFFF,  1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b0, 62'd5000,       3'd0, 24'hFFFFFF,  1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b0, 62'd5000,       3'd7, 24'hFFFFFF,  1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b0, 62'd6000,       3'd5, 24'd12,      1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b0, 62'd10000000,   3'd5, 24'd13,      1'b1, '{1'b0, CLS_POOL, 62'd0}},
        '{1'b0, 62'd20000000,   3'd6, 24'hFFFFFF,  1'b1, '{1'b0, CLS_POOL, 62'd0}},
        '{1'b0, 62'd25000000,   3'd1, 24'd3000,    1'b1, '{1'b0, CLS_NONE, 62'd0}},
        '{1'b0, 62'd30000000,   3'd1, 24'd3001,    1'b1, '{1'b0, CLS_AD, 62'd0}},
        '{1'b0, 62'd40000000,   3'd2, 24'd300001,  1'b1, '{1'b0, CLS_SHOWER, 62'd0}},
        '{1'b0, 62'd41000000,   3'd2, 24'd300000,  1'b1, '{1'b0, CLS_AD, 62'd0}},
        '{1'b0, 62'd50000000,   3'd4, 24'hFFFFFF,  1'b1, '{1'b0, CLS_SHOWER, 62'd0}},
        '{1'b1, 62'd49999000,   3'd4, 24'd0,       1'b0, '0},
        '{1'b1, 62'd50000000,   3'd4, 24'd0,       1'b0, '0},
        '{1'b1, 62'd50000100,   3'd3, 24'd0,       1'b0, '0},
        '{1'b1, 62'd20000005,   3'd5, 24'd0,       1'b0, '0},
        '{1'b1, 62'd20599999,   3'd0, 24'd0,       1'b0, '0},
        '{1'b1, 62'd10000,      3'd1, 24'd0,       1'b0, '0},
        '{1'b0, 62'd0,          3'd3, 24'd5000,    1'b0, '0},
        '{1'b1, 62'd31399999,   3'd1, 24'd0,       1'b0, '0},
        '{1'b1, 62'd31400000,   3'd1, 24'd0,       1'b0, '0},
        '{1'b1, 62'd1000000000, 3'd2, 24'd0,       1'b0, '0},
        '{1'b0, 62'd60000000,   3'd6, 24'd1023,    1'b0, '0},
        '{1'b1, 62'h2AAAAAAAAAAAAAAA, 3'd4, 24'h555555, 1'b0, '0}
    };

    // stimulus
    initial
    begin
        error_count = 0;
        quiet = 1'b0;
        stall_left = 0;
        cursor_ns = 62'd60000000;
        trk_cfg = '{pre: 20'd2000, pool_cut: 10'd12, pool_post: 30'd600000,
                    ad_cut: 24'd3000, ad_post: 30'd1400000, show_cut: 24'd300000,
                    show_post: 30'd400400000};
        last_pool = '0;
        for (int a = 0; a < AD_N; a++)
        begin
            last_ad[a] = '0;
            last_shower[a] = '0;
            dead_acc[a] = '0;
        end
        ring_head = 0;
        ring_fill = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= 1'b0;
        stamp_ns <= '0;
        detector <= '0;
        strength <= '0;
        out_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PRE;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table under reset registers
        foreach (opening_rows[i])
        begin
            send_request(opening_rows[i].kind, opening_rows[i].stamp, opening_rows[i].det,
                         opening_rows[i].str, opening_rows[i].typed, opening_rows[i].reply);
            sender_gap();
        end
        drain();

        // all registers at their lowest
        write_all('0, '0, '0, '0, '0, '0, '0);
        repeat (60)
        begin
            random_request(1'b0);
            sender_gap();
        end
        drain();

        // all cuts at their highest, pre at 1000000 and every post at 1000000000
        write_all(20'd1000000, 10'd1023, 30'd1000000000, 24'hFFFFFF, 30'd1000000000,
                  24'hFFFFFF, 30'd1000000000);
        repeat (60)
        begin
            random_request(1'b0);
            sender_gap();
        end
        drain();

        // mid range settings, with one full pause halfway
        write_all(20'($urandom_range(0, 100000)), 10'($urandom_range(0, 60)),
                  30'($urandom_range(0, 5000000)), 24'($urandom_range(0, 20000)),
                  30'($urandom_range(0, 5000000)), 24'($urandom_range(20000, 800000)),
                  30'($urandom_range(5000000, 1000000000)));
        for (int i = 0; i < 200; i++)
        begin
            random_request(1'b0);
            if (i == 100) drain();
            else sender_gap();
        end
        drain();

        // fill the ring past its depth, then query across it
        write_all(20'd2000, 10'd12, 30'd600000, 24'd3000, 30'd1400000, 24'd300000,
                  30'd400400000);
        repeat (RING_N + 16)
        begin
            random_request(1'b1);
            sender_gap();
        end
        repeat (30)
        begin
            random_request(1'b0);
            sender_gap();
        end
        drain();

        // closing stretch with no idling
        write_all(20'($urandom_range(0, 1000000)), 10'($urandom_range(0, 1023)),
                  30'($urandom_range(0, 1000000000)), 24'($urandom),
                  30'($urandom_range(0, 1000000000)), 24'($urandom),
                  30'($urandom_range(0, 1000000000)));
        quiet = 1'b1;
        repeat (80) random_request(1'b0);
        in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (2 * RING_N + 16) @(posedge clk);
        if (reply_q.size() != 0) error_count++;
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
